// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the index converter.
// No dependencies; take in with `include before the first use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, off while rst_n is low.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that cons holds whenever ante holds, off while rst_n is low.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/pic_pkg.sv -----
// Shared types, codes and helpers of the primitive index converter.
// No dependencies; the front, back, queue and top files refer to it by scoped names.
package pic_pkg;

  localparam int unsigned INDEX_BITS = 32;

  typedef logic [INDEX_BITS-1:0] index_t;
  typedef logic [2:0]            step_t;

  // conv_mode register codes; codes above MODE_LINE_LOOP behave as pass-through
  localparam logic [2:0] MODE_PASS       = 3'd0;
  localparam logic [2:0] MODE_QUADS      = 3'd1;
  localparam logic [2:0] MODE_QUAD_STRIP = 3'd2;
  localparam logic [2:0] MODE_POLYGON    = 3'd3;
  localparam logic [2:0] MODE_LINE_LOOP  = 3'd4;

  // index_kind register codes
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_SHORT = 2'd2;
  localparam logic [1:0] KIND_WORD  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_CONV_MODE    = 2'd0;
  localparam logic [1:0] CFG_INDEX_KIND   = 2'd1;
  localparam logic [1:0] CFG_FIRST_VERTEX = 2'd2;

  localparam int unsigned CFG_DATA_BITS = 31;

  // what the back end emits for one accepted vertex
  typedef enum logic [2:0] {
    OP_NONE,      // nothing emitted, only the closing status result
    OP_SINGLE,    // the vertex index
    OP_LOOP_END,  // the vertex index, then the loop's first index
    OP_QUAD,      // a b c a c d
    OP_STRIP      // a b d a d c
  } op_e;

  typedef struct packed {
    op_e    op;
    logic   last;
    index_t a;
    index_t b;
    index_t c;
    index_t d;
    index_t e;
  } job_t;

  function automatic step_t job_count(op_e op);
    step_t n;
    unique case (op)
      OP_LOOP_END:       n = 3'd2;
      OP_QUAD, OP_STRIP: n = 3'd6;
      default:           n = 3'd1;
    endcase
    return n;
  endfunction

endpackage

// ----- hw/rtl/pic_in_if.sv -----
// Input channel of the index converter: one vertex per transfer.
// No dependencies.
interface pic_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] index_value;
  logic        is_last;

  modport source (output valid, index_value, is_last, input ready);
  modport sink   (input valid, index_value, is_last, output ready);
endinterface

// ----- hw/rtl/pic_out_if.sv -----
// Output channel of the index converter: one index or status result per transfer.
// No dependencies.
interface pic_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_index;
  logic        index_valid;
  logic        run_end;
  logic        draw_end;
  logic [31:0] min_seen;
  logic [31:0] max_seen;
  logic [31:0] emitted_count;

  modport source (output valid, out_index, index_valid, run_end, draw_end,
                  min_seen, max_seen, emitted_count, input ready);
  modport sink   (input valid, out_index, index_valid, run_end, draw_end,
                  min_seen, max_seen, emitted_count, output ready);
endinterface

// ----- hw/rtl/pic_job_fifo.sv -----
// Two-entry queue of classified vertex jobs between front and back end.
// Depends on pic_pkg for the job type.
module pic_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pic_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output pic_pkg::job_t data_o,
  output logic          empty_o
);

  pic_pkg::job_t entry_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- hw/rtl/pic_front.sv -----
// Front end: holds the configuration, accepts vertices, forms the index and
// classifies the vertex into a job. Depends on pic_pkg and pic_in_if.
module pic_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [pic_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  pic_in_if.sink                            in_i,
  output logic                              job_valid_o,
  output pic_pkg::job_t                     job_o,
  input  logic                              job_ready_i
);

  logic [2:0]                        conv_mode_q;
  logic [1:0]                        index_kind_q;
  logic [pic_pkg::CFG_DATA_BITS-1:0] first_vertex_q;

  logic [31:0]     pos_q;
  pic_pkg::index_t win_a_q, win_b_q, win_c_q, loop_first_q;

  logic            fire;
  logic [31:0]     vert_sum;
  pic_pkg::index_t idx;
  pic_pkg::index_t loop_first;
  pic_pkg::op_e    op;

  assign in_i.ready = job_ready_i;
  assign fire       = in_i.valid && in_i.ready;
  assign vert_sum   = {1'b0, first_vertex_q} + pos_q;

  always_comb begin
    unique case (index_kind_q)
      pic_pkg::KIND_BYTE:  idx = pic_pkg::index_t'(in_i.index_value[7:0]);
      pic_pkg::KIND_SHORT: idx = pic_pkg::index_t'(in_i.index_value[15:0]);
      pic_pkg::KIND_WORD:  idx = in_i.index_value[pic_pkg::INDEX_BITS-1:0];
      default:             idx = vert_sum[pic_pkg::INDEX_BITS-1:0];
    endcase
  end

  // only a line loop records its opening index
  assign loop_first = (pos_q == 32'd0 && conv_mode_q == pic_pkg::MODE_LINE_LOOP) ?
                      idx : loop_first_q;

  always_comb begin
    priority if (conv_mode_q == pic_pkg::MODE_QUADS) begin
      op = (pos_q[1:0] == 2'b11) ? pic_pkg::OP_QUAD : pic_pkg::OP_NONE;
    end else if (conv_mode_q == pic_pkg::MODE_QUAD_STRIP) begin
      op = (pos_q[0] && pos_q >= 32'd3) ? pic_pkg::OP_STRIP : pic_pkg::OP_NONE;
    end else if (conv_mode_q == pic_pkg::MODE_LINE_LOOP) begin
      op = in_i.is_last ? pic_pkg::OP_LOOP_END : pic_pkg::OP_SINGLE;
    end else begin
      op = pic_pkg::OP_SINGLE;
    end
  end

  // a last vertex that emits nothing still closes the draw with a status result
  assign job_valid_o = fire && (op != pic_pkg::OP_NONE || in_i.is_last);
  assign job_o = '{op: op, last: in_i.is_last, a: win_a_q, b: win_b_q,
                   c: win_c_q, d: idx, e: loop_first};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_mode_q    <= pic_pkg::MODE_PASS;
      index_kind_q   <= pic_pkg::KIND_NONE;
      first_vertex_q <= '0;
      pos_q          <= '0;
      win_a_q        <= '0;
      win_b_q        <= '0;
      win_c_q        <= '0;
      loop_first_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          pic_pkg::CFG_CONV_MODE:    conv_mode_q    <= cfg_data_i[2:0];
          pic_pkg::CFG_INDEX_KIND:   index_kind_q   <= cfg_data_i[1:0];
          pic_pkg::CFG_FIRST_VERTEX: first_vertex_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (fire) begin
        if (in_i.is_last) begin
          pos_q        <= '0;
          win_a_q      <= '0;
          win_b_q      <= '0;
          win_c_q      <= '0;
          loop_first_q <= '0;
        end else begin
          pos_q        <= pos_q + 32'd1;
          win_a_q      <= win_b_q;
          win_b_q      <= win_c_q;
          win_c_q      <= idx;
          loop_first_q <= loop_first;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/pic_back.sv -----
// Back end: steps through each job one index per cycle unless stalled, keeps
// draw statistics, drives the output register. Depends on pic_pkg, pic_out_if.
module pic_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  pic_pkg::job_t job_i,
  output logic          job_pop_o,
  pic_out_if.source     out_o
);

  logic                out_valid_q;
  pic_pkg::step_t      step_q;
  logic [31:0]         min_q, max_q, cnt_q;
  logic [31:0]         index_q, min_out_q, max_out_q, cnt_out_q;
  logic                index_valid_q, run_end_q, draw_end_q;

  logic                load, fin, draw_end, emit;
  pic_pkg::index_t     val;
  logic [31:0]         val32, min_nx, max_nx, cnt_nx;

  assign load      = job_valid_i && (!out_valid_q || out_o.ready);
  assign fin       = (step_q == pic_pkg::job_count(job_i.op) - 3'd1);
  assign job_pop_o = load && fin;
  assign draw_end  = fin && job_i.last;
  assign emit      = (job_i.op != pic_pkg::OP_NONE);

  always_comb begin
    unique case (job_i.op)
      pic_pkg::OP_QUAD: begin
        unique case (step_q)
          3'd0, 3'd3: val = job_i.a;
          3'd1:       val = job_i.b;
          3'd2, 3'd4: val = job_i.c;
          default:    val = job_i.d;
        endcase
      end
      pic_pkg::OP_STRIP: begin
        unique case (step_q)
          3'd0, 3'd3: val = job_i.a;
          3'd1:       val = job_i.b;
          3'd2, 3'd4: val = job_i.d;
          default:    val = job_i.c;
        endcase
      end
      pic_pkg::OP_LOOP_END: val = (step_q == 3'd0) ? job_i.d : job_i.e;
      default:              val = job_i.d;
    endcase
  end

  assign val32  = 32'(val);
  assign min_nx = (emit && val32 < min_q) ? val32 : min_q;
  assign max_nx = (emit && val32 > max_q) ? val32 : max_q;
  assign cnt_nx = (emit && cnt_q != '1) ? cnt_q + 32'd1 : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= '0;
      min_q       <= '1;
      max_q       <= '0;
      cnt_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        step_q      <= fin ? 3'd0 : step_q + 3'd1;
        if (draw_end) begin
          min_q <= '1;
          max_q <= '0;
          cnt_q <= '0;
        end else begin
          min_q <= min_nx;
          max_q <= max_nx;
          cnt_q <= cnt_nx;
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      index_q       <= emit ? val32 : 32'd0;
      index_valid_q <= emit;
      run_end_q     <= fin;
      draw_end_q    <= draw_end;
      min_out_q     <= draw_end ? min_nx : 32'd0;
      max_out_q     <= draw_end ? max_nx : 32'd0;
      cnt_out_q     <= draw_end ? cnt_nx : 32'd0;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_index     = index_q;
  assign out_o.index_valid   = index_valid_q;
  assign out_o.run_end       = run_end_q;
  assign out_o.draw_end      = draw_end_q;
  assign out_o.min_seen      = min_out_q;
  assign out_o.max_seen      = max_out_q;
  assign out_o.emitted_count = cnt_out_q;

endmodule

// ----- hw/rtl/primitive_index_converter.sv -----
// Primitive index converter top level: front end, job queue and back end.
// Depends on pic_pkg, pic_in_if, pic_out_if, pic_front, pic_job_fifo, pic_back.
//
// Turns a stream of vertices into a 32-bit index list. Each vertex is one
// input transfer; the front end forms its index (masked raw index or
// first_vertex plus position), classifies it by conv_mode and pushes a job
// into a two-entry queue when the vertex emits or closes the draw. The back
// end expands each job into one, two or six output transfers, one per cycle
// while the output is not stalled, from its output register, and tracks the
// minimum, maximum and saturating count of the draw, reported on the result
// flagged draw_end. The input takes one vertex per cycle while the queue has
// room; output is one result per cycle while out ready holds, set by the
// back end's single output register. Each job is registered in the queue
// and its results in the back end's output register.
// Configuration writes take effect on the next vertex and are meant for idle
// periods between draws.
module primitive_index_converter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [pic_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  pic_in_if.sink                            in_i,
  pic_out_if.source                         out_o
);

  pic_pkg::job_t push_job, head_job;
  logic          push, full, empty, pop;

  // classify vertices; stall input only when the queue is full
  pic_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .job_valid_o (push),
    .job_o       (push_job),
    .job_ready_i (!full)
  );

  // decouple vertex intake from result output
  pic_job_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_job),
    .empty_o (empty)
  );

  // expand the head job into results; drop it once its last result is loaded into the output register
  pic_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!empty),
    .job_i       (head_job),
    .job_pop_o   (pop),
    .out_o       (out_o)
  );

endmodule

// ----- hw/rtl/pic_checker.sv -----
// Port-level checks of the index converter output channel, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module pic_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_index_i,
  input logic        index_valid_i,
  input logic        run_end_i,
  input logic        draw_end_i,
  input logic [31:0] min_seen_i,
  input logic [31:0] max_seen_i,
  input logic [31:0] emitted_count_i
);

  `ASSERT_AT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_index_i) && $stable(draw_end_i), "stalled result changed")
  `ASSERT_IMPL(a_draw_closes_run, clk_i, rst_ni, out_valid_i && draw_end_i, run_end_i, "draw end without run end")
  `ASSERT_IMPL(a_empty_is_final, clk_i, rst_ni, out_valid_i && !index_valid_i, draw_end_i && out_index_i == 32'd0, "empty result not closing a draw")
  `ASSERT_IMPL(a_stats_quiet, clk_i, rst_ni, out_valid_i && !draw_end_i, min_seen_i == 32'd0 && max_seen_i == 32'd0 && emitted_count_i == 32'd0, "statistics outside draw end")
  `ASSERT_IMPL(a_stats_cover, clk_i, rst_ni, out_valid_i && draw_end_i && index_valid_i, min_seen_i <= out_index_i && out_index_i <= max_seen_i && emitted_count_i != 32'd0, "final index outside statistics")

endmodule

bind primitive_index_converter pic_checker u_pic_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_index_i     (out_o.out_index),
  .index_valid_i   (out_o.index_valid),
  .run_end_i       (out_o.run_end),
  .draw_end_i      (out_o.draw_end),
  .min_seen_i      (out_o.min_seen),
  .max_seen_i      (out_o.max_seen),
  .emitted_count_i (out_o.emitted_count)
);
